### hw/rtl/bir_pkg.sv
package bir_pkg;

  // Fixed widths of the request fields and the registers
  localparam int COORD_W = 8;
  localparam int SIZE_W  = 9;
  localparam int STEP_W  = 25;
  localparam int POS_W   = COORD_W + STEP_W;
  localparam int CFG_IDX_W = 3;

  typedef enum logic {
    FUNC_STORE   = 1'b0,
    FUNC_COMPUTE = 1'b1
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 3'd0,
    REG_SOURCE_HEIGHT = 3'd1,
    REG_STEP_X        = 3'd2,
    REG_STEP_Y        = 3'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // Corner order of the blend: top left, top right, bottom left, bottom right
  localparam int CORNERS = 4;
  localparam int CHANNELS = 3;

endpackage

### hw/rtl/bir_frame_mem.sv
module bir_frame_mem
  import bir_pkg::*;
#(
  parameter int AW = 14
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [1:0]    wr_bank,
  input  logic [AW-1:0] wr_addr,
  input  pixel_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr [CORNERS],
  output pixel_t        rd_data [CORNERS]
);

  localparam int DEPTH = 1 << AW;

  // Four banks split by row parity (bit 1) and column parity (bit 0)
  for (genvar b = 0; b < CORNERS; b++) begin : g_bank
    pixel_t mem [DEPTH];

    always_ff @(posedge clk) begin
      if (wr_en && (wr_bank == 2'(b))) begin
        mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
        rd_data[b] <= mem[rd_addr[b]];
      end
    end
  end

endmodule

### hw/rtl/bir_locate.sv
module bir_locate
  import bir_pkg::*;
#(
  parameter int IDX_W = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic [POS_W-1:0]     pos,
  input  logic [IDX_W-1:0]     last,
  output logic [IDX_W-1:0]     lo,
  output logic [IDX_W-1:0]     hi,
  output logic [FRAC_BITS-1:0] frac
);

  localparam int PW = POS_W - FRAC_BITS;
  localparam int CW = ((PW > IDX_W) ? PW : IDX_W) + 1;

  logic [PW-1:0] ip;
  logic [CW-1:0] ip_e;
  logic [CW-1:0] ip1_e;
  logic [CW-1:0] last_e;

  always_comb begin
    ip     = pos[POS_W-1:FRAC_BITS];
    frac   = pos[FRAC_BITS-1:0];
    ip_e   = CW'(ip);
    ip1_e  = ip_e + CW'(1);
    last_e = CW'(last);
    // clamp both neighbours to the last column or row
    lo = (ip_e > last_e) ? last : IDX_W'(ip_e);
    hi = (ip1_e > last_e) ? last : IDX_W'(ip1_e);
  end

endmodule

### hw/rtl/bilinear_image_resize_core.sv
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | func, col, row, blue_in, green_in, red_in
// out_    | output    | out_valid/out_stall| blue_out, green_out, red_out
// cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One request per cycle sustained while out_stall is low; after acceptance a compute
// result passes the multiply, memory read, weight product and final sum stages in order.
// Four parity banks give all four neighbours in one read of the frame memory.
// Reset (rst_n low, synchronous) clears pipeline valids and sets the registers to defaults;
// the frame memory is not cleared and holds nothing until stored.
// A stalled output only holds the stages behind it as far as bubbles allow.
module bilinear_image_resize_core
  import bir_pkg::*;
#(
  parameter int MAX_WIDTH = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRACTION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_func,
  input  logic [COORD_W-1:0]   in_col,
  input  logic [COORD_W-1:0]   in_row,
  input  logic [7:0]           in_blue_in,
  input  logic [7:0]           in_green_in,
  input  logic [7:0]           in_red_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_blue_out,
  output logic [7:0]           out_green_out,
  output logic [7:0]           out_red_out,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [STEP_W-1:0]    cfg_data
);

  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int XH = (XW > 1) ? XW - 1 : 1;
  localparam int YH = (YW > 1) ? YW - 1 : 1;
  localparam int AW = XH + YH;
  localparam int LWX = ((XW + 1) > SIZE_W) ? XW + 1 : SIZE_W;
  localparam int LWY = ((YW + 1) > SIZE_W) ? YW + 1 : SIZE_W;
  localparam int FB = FRACTION_BITS;
  localparam int WW = 2 * FB + 2;
  localparam int PRW = WW + 8;
  localparam int SW = PRW + 2;

  // configuration registers
  logic [SIZE_W-1:0] src_width_r, src_height_r;
  logic [STEP_W-1:0] step_x_r, step_y_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= SIZE_W'(256);
      src_height_r <= SIZE_W'(256);
      step_x_r     <= STEP_W'(65536);
      step_y_r     <= STEP_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SOURCE_WIDTH:  src_width_r  <= cfg_data[SIZE_W-1:0];
        REG_SOURCE_HEIGHT: src_height_r <= cfg_data[SIZE_W-1:0];
        REG_STEP_X:        step_x_r     <= cfg_data;
        REG_STEP_Y:        step_y_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame size limited to 1..MAX
  logic [LWX-1:0] w_cfg, w_lim;
  logic [LWY-1:0] h_cfg, h_lim;
  logic [XW-1:0]  last_x;
  logic [YW-1:0]  last_y;

  always_comb begin
    w_cfg = LWX'(src_width_r);
    h_cfg = LWY'(src_height_r);
    w_lim = (w_cfg == '0) ? LWX'(1) : (w_cfg > LWX'(MAX_WIDTH)) ? LWX'(MAX_WIDTH) : w_cfg;
    h_lim = (h_cfg == '0) ? LWY'(1) : (h_cfg > LWY'(MAX_HEIGHT)) ? LWY'(MAX_HEIGHT) : h_cfg;
    last_x = XW'(w_lim - LWX'(1));
    last_y = YW'(h_lim - LWY'(1));
  end

  // stage enables: a stage loads when it is empty or the next one loads
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic en1, en2, en3, en4, en_out;

  always_comb begin
    en_out = !out_valid_r || !out_stall;
    en4    = !v4_r || en_out;
    en3    = !v3_r || en4;
    en2    = !v2_r || en3;
    en1    = !v1_r || en2;
  end

  assign in_stall  = !en1;
  assign out_valid = out_valid_r;

  // stage 1: registered request
  func_t        func1_r;
  logic [COORD_W-1:0] col1_r, row1_r;
  pixel_t       pix1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      func1_r <= func_t'(in_func);
      col1_r  <= in_col;
      row1_r  <= in_row;
      pix1_r  <= '{red: in_red_in, green: in_green_in, blue: in_blue_in};
    end
  end

  // stage 2: source position
  func_t              func2_r;
  logic [COORD_W-1:0] col2_r, row2_r;
  pixel_t             pix2_r;
  logic [POS_W-1:0]   pos_x_nxt, pos_y_nxt, pos_x_r, pos_y_r;

  assign pos_x_nxt = POS_W'(col1_r) * POS_W'(step_x_r);
  assign pos_y_nxt = POS_W'(row1_r) * POS_W'(step_y_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      func2_r <= func1_r;
      col2_r  <= col1_r;
      row2_r  <= row1_r;
      pix2_r  <= pix1_r;
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
    end
  end

  logic [XW-1:0] x0, x1;
  logic [YW-1:0] y0, y1;
  logic [FB-1:0] fx, fy;

  bir_locate #(.IDX_W(XW), .FRAC_BITS(FB)) u_loc_x (
    .pos(pos_x_r), .last(last_x), .lo(x0), .hi(x1), .frac(fx)
  );

  bir_locate #(.IDX_W(YW), .FRAC_BITS(FB)) u_loc_y (
    .pos(pos_y_r), .last(last_y), .lo(y0), .hi(y1), .frac(fy)
  );

  // weights of the four corners
  logic [FB:0]   ofx, ofy;
  logic [WW-1:0] wt_nxt [CORNERS];

  always_comb begin
    ofx = (FB+1)'(1 << FB) - (FB+1)'(fx);
    ofy = (FB+1)'(1 << FB) - (FB+1)'(fy);
    wt_nxt[0] = WW'(ofx) * WW'(ofy);
    wt_nxt[1] = WW'(fx) * WW'(ofy);
    wt_nxt[2] = WW'(ofx) * WW'(fy);
    wt_nxt[3] = WW'(fx) * WW'(fy);
  end

  // memory access: an in-range store writes, a compute reads one neighbour per bank
  logic          mem_we, store_ok;
  logic [1:0]    wr_bank;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr [CORNERS];
  pixel_t        rd_data [CORNERS];
  logic [XW-1:0] xsel;
  logic [YW-1:0] ysel;

  always_comb begin
    store_ok = (32'(col2_r) < MAX_WIDTH) && (32'(row2_r) < MAX_HEIGHT);
    mem_we   = en2 && v2_r && (func2_r == FUNC_STORE) && store_ok;
    wr_bank  = {row2_r[0], col2_r[0]};
    wr_addr  = {YH'(row2_r >> 1), XH'(col2_r >> 1)};
    for (int b = 0; b < CORNERS; b++) begin
      xsel = (x0[0] == b[0]) ? x0 : x1;
      ysel = (y0[0] == b[1]) ? y0 : y1;
      rd_addr[b] = {YH'(ysel >> 1), XH'(xsel >> 1)};
    end
  end

  // read data belongs to stage 3, so capture it only when stage 3 loads
  bir_frame_mem #(.AW(AW)) u_mem (
    .clk(clk),
    .wr_en(mem_we),
    .wr_bank(wr_bank),
    .wr_addr(wr_addr),
    .wr_data(pix2_r),
    .rd_en(en3),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // stage 3: neighbour data and weights
  logic [WW-1:0] wt_r [CORNERS];
  logic [1:0]    bank_r [CORNERS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r && (func2_r == FUNC_COMPUTE);
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      wt_r     <= wt_nxt;
      bank_r[0] <= {y0[0], x0[0]};
      bank_r[1] <= {y0[0], x1[0]};
      bank_r[2] <= {y1[0], x0[0]};
      bank_r[3] <= {y1[0], x1[0]};
    end
  end

  logic [PRW-1:0] prod_nxt [CORNERS][CHANNELS];
  logic [PRW-1:0] prod_r   [CORNERS][CHANNELS];
  logic [23:0]    cbits;

  always_comb begin
    for (int c = 0; c < CORNERS; c++) begin
      cbits = rd_data[bank_r[c]];
      for (int ch = 0; ch < CHANNELS; ch++) begin
        prod_nxt[c][ch] = PRW'(cbits[8*ch +: 8]) * PRW'(wt_r[c]);
      end
    end
  end

  // stage 4: weighted products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      prod_r <= prod_nxt;
    end
  end

  logic [SW-1:0] sum [CHANNELS];

  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      sum[ch] = SW'(prod_r[0][ch]) + SW'(prod_r[1][ch])
              + SW'(prod_r[2][ch]) + SW'(prod_r[3][ch]);
    end
  end

  // output register: drop the fraction bits of the sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_blue_out  <= sum[0][2*FB +: 8];
      out_green_out <= sum[1][2*FB +: 8];
      out_red_out   <= sum[2][2*FB +: 8];
    end
  end

  // input held back only when every stage holds an item
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && v4_r && out_valid_r))
    else $error("input stalled with a bubble in the pipeline");

  a_write_store: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (v2_r && (func2_r == FUNC_STORE)))
    else $error("frame write without a store request");

  a_compute_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (en2 && v2_r && (func2_r == FUNC_COMPUTE)) |=> v3_r)
    else $error("compute request lost at memory read");

  a_store_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (en2 && v2_r && (func2_r == FUNC_STORE)) |=> !v3_r)
    else $error("store request produced a result");

endmodule
